[rtl/core/fcsa_pkg.sv]
package fcsa_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 64;
	localparam logic [15:0] AGE_MAX = 16'hFFFF;
	localparam logic [15:0] THRESHOLD_RESET = 16'd40;
	localparam logic [7:0] BROADCAST_STATUS = 8'h09;

	// opcodes
	localparam logic [2:0] OP_TICK = 3'd0;
	localparam logic [2:0] OP_ADD = 3'd1;
	localparam logic [2:0] OP_CLEAR = 3'd2;
	localparam logic [2:0] OP_READ = 3'd3;
	localparam logic [2:0] OP_QUERY = 3'd4;

	typedef struct packed {
		logic [2:0] opcode;
		logic [31:0] dtc_code;
		logic [7:0] new_status;
		logic [7:0] query_mask;
		logic [5:0] entry_index;
		logic [6:0] max_matches;
		logic [15:0] speed_in;
		logic [15:0] current_in;
		logic [15:0] voltage_in;
		logic [7:0] temp_in;
	} cmd_t;

	typedef struct packed {
		logic [31:0] out_code;
		logic [7:0] out_status;
		logic [15:0] out_aging;
		logic [15:0] out_speed;
		logic [15:0] out_current;
		logic [15:0] out_voltage;
		logic [7:0] out_temp;
		logic [31:0] out_stamp;
		logic ok_flag;
		logic [6:0] count_now;
		logic last_flag;
	} result_t;

	typedef struct packed {
		logic [31:0] code;
		logic [7:0] status;
		logic [15:0] aging;
		logic [15:0] speed;
		logic [15:0] current;
		logic [15:0] voltage;
		logic [7:0] temp;
		logic [31:0] stamp;
	} entry_t;

endpackage

[rtl/core/fault_code_store_with_aging.sv]
// channel   | direction | handshake                   | payload
// command   | in        | start high, busy low        | cmd (fcsa_pkg::cmd_t)
// result    | out       | result_valid strobe, 1 cycle | result (fcsa_pkg::result_t)
// config    | in        | cfg_valid and cfg_ready     | cfg_data (aging threshold)
//
// One command at a time; busy is high from accept until its last result.
// Commands answered from idle (clear, rejected add or read, bad op) never
// raise busy. Every table visit is a read step then an evaluate step on the
// entry memory, which has one write port and one read port.
// arst_n clears all control state; no memory clearing pass is needed.
// The receiver cannot stall: results are strobed out as they are produced.
module fault_code_store_with_aging #(
	parameter int unsigned TABLE_DEPTH = fcsa_pkg::TABLE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input fcsa_pkg::cmd_t cmd,
	output logic result_valid,
	output fcsa_pkg::result_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [15:0] cfg_data
);

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	typedef enum logic [7:0] {
		S_IDLE    = 8'b00000001,
		S_SRCH_RD = 8'b00000010,
		S_SRCH_EX = 8'b00000100,
		S_AGE_RD  = 8'b00001000,
		S_AGE_EX  = 8'b00010000,
		S_READ_EX = 8'b00100000,
		S_QRY_RD  = 8'b01000000,
		S_QRY_EX  = 8'b10000000
	} state_t;

	state_t state_q;
	fcsa_pkg::cmd_t cmd_q;
	fcsa_pkg::entry_t mem [TABLE_DEPTH];
	fcsa_pkg::entry_t rd_q;
	fcsa_pkg::result_t res_q;
	logic res_valid_q;
	logic [CW-1:0] total_q, wp_q, i_q, w_q, found_q, cap_q;
	logic [31:0] tick_q;
	logic [15:0] thr_q;
	logic is_tick_q;
	logic pend_q;
	logic [31:0] pend_code_q;

	logic wr_en;
	logic [AW-1:0] wr_addr, rd_addr;
	fcsa_pkg::entry_t wr_data, ins_entry, hit_entry, aged_entry;
	logic [AW-1:0] ins_slot;
	logic hit, drop, qry_match;
	logic [15:0] age_inc;
	logic [7:0] cap_in;

	// result with no entry fields
	function automatic fcsa_pkg::result_t brief_result(logic ok, logic [CW-1:0] count,
		logic [31:0] code, logic last);
		fcsa_pkg::result_t r;
		r = '0;
		r.out_code = code;
		r.ok_flag = ok;
		r.count_now = 7'(count);
		r.last_flag = last;
		return r;
	endfunction

	assign busy = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign result_valid = res_valid_q;
	assign result = res_q;

	// slot for a new entry: append, or circular overwrite when full
	always_comb begin
		if (total_q < DEPTH_C)
			ins_slot = total_q[AW-1:0];
		else if (wp_q >= DEPTH_C)
			ins_slot = '0;
		else
			ins_slot = wp_q[AW-1:0];
	end

	// entry images for insert, hit update and aging
	always_comb begin
		ins_entry = '{code: cmd_q.dtc_code,
			status: is_tick_q ? fcsa_pkg::BROADCAST_STATUS : cmd_q.new_status,
			aging: 16'd0, speed: cmd_q.speed_in, current: cmd_q.current_in,
			voltage: cmd_q.voltage_in, temp: cmd_q.temp_in, stamp: tick_q};
		hit_entry = rd_q;
		hit_entry.status = rd_q.status |
			(is_tick_q ? fcsa_pkg::BROADCAST_STATUS : cmd_q.new_status);
		hit_entry.aging = 16'd0;
		hit = (rd_q.code == cmd_q.dtc_code);
		age_inc = (rd_q.aging == fcsa_pkg::AGE_MAX) ? rd_q.aging : rd_q.aging + 16'd1;
		aged_entry = rd_q;
		if (!rd_q.status[0])
			aged_entry.aging = age_inc;
		drop = !rd_q.status[0] && (age_inc >= thr_q);
		qry_match = (rd_q.status & cmd_q.query_mask) != 8'd0;
		cap_in = (8'(cmd.max_matches) > 8'(TABLE_DEPTH)) ? 8'(TABLE_DEPTH)
			: 8'(cmd.max_matches);
	end

	// memory write port
	always_comb begin
		wr_en = 1'b0;
		wr_addr = i_q[AW-1:0];
		wr_data = ins_entry;
		unique case (state_q)
			S_SRCH_RD: begin
				if (i_q >= total_q) begin
					wr_en = 1'b1;
					wr_addr = ins_slot;
				end
			end
			S_SRCH_EX: begin
				wr_en = hit;
				wr_data = hit_entry;
			end
			S_AGE_EX: begin
				wr_en = !drop;
				wr_addr = w_q[AW-1:0];
				wr_data = aged_entry;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
		rd_addr = (state_q == S_IDLE) ? AW'(8'(cmd.entry_index)) : i_q[AW-1:0];
	end

	// entry memory
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q <= '0;
			res_q <= '0;
			total_q <= '0;
			wp_q <= '0;
			tick_q <= '0;
			thr_q <= fcsa_pkg::THRESHOLD_RESET;
			res_valid_q <= 1'b0;
			i_q <= '0;
			w_q <= '0;
			found_q <= '0;
			cap_q <= '0;
			is_tick_q <= 1'b0;
			pend_q <= 1'b0;
			pend_code_q <= '0;
		end else begin
			res_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready)
				thr_q <= cfg_data;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q <= cmd;
						i_q <= '0;
						w_q <= '0;
						found_q <= '0;
						pend_q <= 1'b0;
						cap_q <= CW'(cap_in);
						is_tick_q <= (cmd.opcode == fcsa_pkg::OP_TICK);
						priority case (cmd.opcode)
							fcsa_pkg::OP_TICK: begin
								tick_q <= tick_q + 32'd1;
								state_q <= (cmd.dtc_code != 32'd0) ? S_SRCH_RD : S_AGE_RD;
							end
							fcsa_pkg::OP_ADD: begin
								if (cmd.dtc_code != 32'd0) begin
									state_q <= S_SRCH_RD;
								end else begin
									res_q <= brief_result(1'b0, total_q, 32'd0, 1'b1);
									res_valid_q <= 1'b1;
								end
							end
							fcsa_pkg::OP_CLEAR: begin
								total_q <= '0;
								wp_q <= '0;
								res_q <= brief_result(1'b1, '0, 32'd0, 1'b1);
								res_valid_q <= 1'b1;
							end
							fcsa_pkg::OP_READ: begin
								if (8'(cmd.entry_index) < 8'(total_q)) begin
									state_q <= S_READ_EX;
								end else begin
									res_q <= brief_result(1'b0, total_q, 32'd0, 1'b1);
									res_valid_q <= 1'b1;
								end
							end
							fcsa_pkg::OP_QUERY: begin
								state_q <= S_QRY_RD;
							end
							default: begin
								res_q <= brief_result(1'b0, total_q, 32'd0, 1'b1);
								res_valid_q <= 1'b1;
							end
						endcase
					end
				end
				S_SRCH_RD: begin
					if (i_q >= total_q) begin
						// not found: insert
						if (total_q < DEPTH_C) begin
							total_q <= total_q + CW'(1);
							wp_q <= total_q + CW'(1);
						end else begin
							wp_q <= CW'(ins_slot) + CW'(1);
						end
						if (is_tick_q) begin
							i_q <= '0;
							state_q <= S_AGE_RD;
						end else begin
							res_q <= brief_result(1'b1, (total_q < DEPTH_C) ?
								total_q + CW'(1) : total_q, 32'd0, 1'b1);
							res_valid_q <= 1'b1;
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_SRCH_EX;
					end
				end
				S_SRCH_EX: begin
					if (hit) begin
						if (is_tick_q) begin
							i_q <= '0;
							state_q <= S_AGE_RD;
						end else begin
							res_q <= brief_result(1'b1, total_q, 32'd0, 1'b1);
							res_valid_q <= 1'b1;
							state_q <= S_IDLE;
						end
					end else begin
						i_q <= i_q + CW'(1);
						state_q <= S_SRCH_RD;
					end
				end
				S_AGE_RD: begin
					if (i_q >= total_q) begin
						total_q <= w_q;
						res_q <= brief_result(1'b1, w_q, 32'd0, 1'b1);
						res_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_AGE_EX;
					end
				end
				S_AGE_EX: begin
					// compaction: kept entries move down to the write index
					if (drop) begin
						if (wp_q != '0)
							wp_q <= wp_q - CW'(1);
					end else begin
						w_q <= w_q + CW'(1);
					end
					i_q <= i_q + CW'(1);
					state_q <= S_AGE_RD;
				end
				S_READ_EX: begin
					res_q <= '{out_code: rd_q.code, out_status: rd_q.status,
						out_aging: rd_q.aging, out_speed: rd_q.speed,
						out_current: rd_q.current, out_voltage: rd_q.voltage,
						out_temp: rd_q.temp, out_stamp: rd_q.stamp, ok_flag: 1'b1,
						count_now: 7'(total_q), last_flag: 1'b1};
					res_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_QRY_RD: begin
					if (i_q >= total_q || found_q == cap_q) begin
						// final transfer: held match, or a single miss
						res_q <= brief_result(pend_q, total_q,
							pend_q ? pend_code_q : 32'd0, 1'b1);
						res_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_QRY_EX;
					end
				end
				S_QRY_EX: begin
					// one match is held back so the last one can be flagged
					if (qry_match) begin
						if (pend_q) begin
							res_q <= brief_result(1'b1, total_q, pend_code_q, 1'b0);
							res_valid_q <= 1'b1;
						end
						pend_q <= 1'b1;
						pend_code_q <= rd_q.code;
						found_q <= found_q + CW'(1);
					end
					i_q <= i_q + CW'(1);
					state_q <= S_QRY_RD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// table bookkeeping stays in range
	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= DEPTH_C && wp_q <= DEPTH_C)
		else $error("entry count or write pointer out of range");

	// compaction never writes ahead of the read index
	a_compact_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_AGE_EX || state_q == S_AGE_RD) |-> w_q <= i_q)
		else $error("compaction write index passed read index");

	// a result only follows a command in progress
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy) || $past(start))
		else $error("result without a command");

	// no new command while a query still holds a match
	a_pend_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q && state_q == S_QRY_EX) |-> busy)
		else $error("held query match while idle");

endmodule

[verif/fault_code_store_with_aging_tb.sv]
`timescale 1ns / 1ps

module fault_code_store_with_aging_tb;

	localparam int DEPTH = fcsa_pkg::TABLE_DEPTH_DEF;
	localparam logic [7:0] ST_TEST_FAILED = 8'h01;
	localparam logic [2:0] OP_BAD = 3'd5;
	localparam logic [2:0] OP_BAD_TOP = 3'd7;
	localparam int CYCLE_LIMIT = 1500000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	fcsa_pkg::cmd_t cmd = '0;
	logic result_valid;
	fcsa_pkg::result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [15:0] cfg_data = '0;

	fault_code_store_with_aging u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.result_valid(result_valid),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// shadow copy of the fault table
	fcsa_pkg::entry_t tbl [DEPTH];
	int unsigned n_entries;
	int unsigned wr_ptr;
	logic [31:0] ticks;
	logic [15:0] threshold;

	fcsa_pkg::result_t pending_results[$];
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	int sender_idle_pct = 0;

	task automatic report_mismatch(input string what);
		error_count++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	function automatic void store_entry(int unsigned slot, logic [31:0] code,
		logic [7:0] status, fcsa_pkg::cmd_t c);
		tbl[slot] = '{code: code, status: status, aging: '0, speed: c.speed_in,
			current: c.current_in, voltage: c.voltage_in, temp: c.temp_in,
			stamp: ticks};
	endfunction

	function automatic bit insert_code(logic [31:0] code, logic [7:0] status,
		fcsa_pkg::cmd_t c);
		if (code == 0)
			return 1'b0;
		for (int i = 0; i < n_entries; i++) begin
			if (tbl[i].code == code) begin
				tbl[i].status |= status;
				tbl[i].aging = '0;
				return 1'b1;
			end
		end
		if (n_entries < DEPTH) begin
			store_entry(n_entries, code, status, c);
			n_entries++;
			wr_ptr = n_entries;
		end else begin
			if (wr_ptr >= DEPTH)
				wr_ptr = 0;
			store_entry(wr_ptr, code, status, c);
			wr_ptr++;
		end
		return 1'b1;
	endfunction

	function automatic void wipe_table();
		for (int i = 0; i < DEPTH; i++)
			tbl[i] = '0;
		n_entries = 0;
		wr_ptr = 0;
	endfunction

	// compute the results of one command and update the shadow table
	function automatic void predict_command(fcsa_pkg::cmd_t c);
		fcsa_pkg::result_t r;
		int unsigned i;
		int unsigned cap;
		int unsigned found;
		bit ok;
		r = '0;
		ok = 1'b1;
		if (c.opcode == fcsa_pkg::OP_QUERY) begin
			cap = (c.max_matches > DEPTH) ? DEPTH : c.max_matches;
			found = 0;
			for (i = 0; i < n_entries && found < cap; i++) begin
				if ((tbl[i].status & c.query_mask) != 0) begin
					r = '0;
					r.out_code = tbl[i].code;
					r.ok_flag = 1'b1;
					r.count_now = 7'(n_entries);
					pending_results.push_back(r);
					found++;
				end
			end
			if (found == 0) begin
				r = '0;
				r.count_now = 7'(n_entries);
				r.last_flag = 1'b1;
				pending_results.push_back(r);
			end else begin
				pending_results[$].last_flag = 1'b1;
			end
			return;
		end
		case (c.opcode)
			fcsa_pkg::OP_TICK: begin
				ticks++;
				void'(insert_code(c.dtc_code, fcsa_pkg::BROADCAST_STATUS, c));
				i = 0;
				while (i < n_entries) begin
					if ((tbl[i].status & ST_TEST_FAILED) == 0) begin
						if (tbl[i].aging < fcsa_pkg::AGE_MAX)
							tbl[i].aging++;
						if (tbl[i].aging >= threshold) begin
							for (int j = i; j + 1 < n_entries; j++)
								tbl[j] = tbl[j + 1];
							n_entries--;
							if (wr_ptr > 0)
								wr_ptr--;
							continue;
						end
					end
					i++;
				end
			end
			fcsa_pkg::OP_ADD: ok = insert_code(c.dtc_code, c.new_status, c);
			fcsa_pkg::OP_CLEAR: wipe_table();
			fcsa_pkg::OP_READ: begin
				if (c.entry_index < n_entries) begin
					r.out_code = tbl[c.entry_index].code;
					r.out_status = tbl[c.entry_index].status;
					r.out_aging = tbl[c.entry_index].aging;
					r.out_speed = tbl[c.entry_index].speed;
					r.out_current = tbl[c.entry_index].current;
					r.out_voltage = tbl[c.entry_index].voltage;
					r.out_temp = tbl[c.entry_index].temp;
					r.out_stamp = tbl[c.entry_index].stamp;
				end else begin
					ok = 1'b0;
				end
			end
			default: ok = 1'b0;
		endcase
		r.ok_flag = ok;
		r.count_now = 7'(n_entries);
		r.last_flag = 1'b1;
		pending_results.push_back(r);
	endfunction

	// check each result transfer against the oldest expectation
	always @(posedge clk) begin
		fcsa_pkg::result_t e;
		if (arst_n && result_valid) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result code=%h", result.out_code));
			end else begin
				e = pending_results.pop_front();
				if (result.out_code !== e.out_code)
					report_mismatch($sformatf("out_code %h exp %h", result.out_code, e.out_code));
				if (result.out_status !== e.out_status)
					report_mismatch($sformatf("out_status %h exp %h", result.out_status,
						e.out_status));
				if (result.out_aging !== e.out_aging)
					report_mismatch($sformatf("out_aging %h exp %h", result.out_aging,
						e.out_aging));
				if (result.out_speed !== e.out_speed)
					report_mismatch($sformatf("out_speed %h exp %h", result.out_speed,
						e.out_speed));
				if (result.out_current !== e.out_current)
					report_mismatch($sformatf("out_current %h exp %h", result.out_current,
						e.out_current));
				if (result.out_voltage !== e.out_voltage)
					report_mismatch($sformatf("out_voltage %h exp %h", result.out_voltage,
						e.out_voltage));
				if (result.out_temp !== e.out_temp)
					report_mismatch($sformatf("out_temp %h exp %h", result.out_temp, e.out_temp));
				if (result.out_stamp !== e.out_stamp)
					report_mismatch($sformatf("out_stamp %h exp %h", result.out_stamp,
						e.out_stamp));
				if (result.ok_flag !== e.ok_flag)
					report_mismatch($sformatf("ok_flag %b exp %b", result.ok_flag, e.ok_flag));
				if (result.count_now !== e.count_now)
					report_mismatch($sformatf("count_now %0d exp %0d", result.count_now,
						e.count_now));
				if (result.last_flag !== e.last_flag)
					report_mismatch($sformatf("last_flag %b exp %b", result.last_flag,
						e.last_flag));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// one command transfer, with optional random idle cycles before it;
	// start stays high after the transfer so commands can follow back to back
	task automatic send_command(fcsa_pkg::cmd_t c);
		if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < sender_idle_pct);
		end
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_command(c);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0 || busy)
			@(posedge clk);
		repeat (300)
			@(posedge clk);
	endtask

	task automatic write_threshold(logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		threshold = value;
	endtask

	function automatic fcsa_pkg::cmd_t make_cmd(logic [2:0] op, logic [31:0] code,
		logic [7:0] status, logic [7:0] mask, logic [5:0] idx, logic [6:0] cap);
		fcsa_pkg::cmd_t c;
		c = '0;
		c.opcode = op;
		c.dtc_code = code;
		c.new_status = status;
		c.query_mask = mask;
		c.entry_index = idx;
		c.max_matches = cap;
		c.speed_in = 16'($urandom);
		c.current_in = 16'($urandom);
		c.voltage_in = 16'($urandom);
		c.temp_in = 8'($urandom);
		return c;
	endfunction

	// random command, mostly on a small pool of codes so updates and aging happen
	function automatic fcsa_pkg::cmd_t random_cmd();
		int unsigned pick;
		logic [31:0] code;
		logic [2:0] op;
		pick = $urandom_range(99);
		code = ($urandom_range(3) == 0) ? $urandom : $urandom_range(80);
		if (pick < 30)
			op = fcsa_pkg::OP_TICK;
		else if (pick < 62)
			op = fcsa_pkg::OP_ADD;
		else if (pick < 64)
			op = fcsa_pkg::OP_CLEAR;
		else if (pick < 80)
			op = fcsa_pkg::OP_READ;
		else if (pick < 97)
			op = fcsa_pkg::OP_QUERY;
		else
			op = 3'($urandom_range(5, 7));
		if (op == fcsa_pkg::OP_TICK && $urandom_range(2) != 0)
			code = '0;
		return make_cmd(op, code, 8'($urandom), 8'($urandom), 6'($urandom),
			($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(64)));
	endfunction

	typedef struct {
		logic [2:0] op;
		logic [31:0] code;
		logic [7:0] status;
		logic [7:0] mask;
		logic [5:0] idx;
		logic [6:0] cap;
	} directed_row_t;

	directed_row_t directed_rows[] = '{
		'{fcsa_pkg::OP_READ, 32'h0, 8'h00, 8'h00, 6'd0, 7'd0},
		'{fcsa_pkg::OP_ADD, 32'h0, 8'hFF, 8'h00, 6'd0, 7'd0},
		'{fcsa_pkg::OP_QUERY, 32'h0, 8'h00, 8'hFF, 6'd0, 7'd64},
		'{OP_BAD, 32'h0, 8'h00, 8'h00, 6'd0, 7'd0},
		'{OP_BAD_TOP, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 6'd63, 7'd127},
		'{fcsa_pkg::OP_ADD, 32'hFFFF_FFFF, 8'h00, 8'h00, 6'd0, 7'd0},
		'{fcsa_pkg::OP_ADD, 32'h0000_0001, 8'hFF, 8'h00, 6'd0, 7'd0},
		'{fcsa_pkg::OP_ADD, 32'hFFFF_FFFF, 8'h01, 8'h00, 6'd0, 7'd0},
		'{fcsa_pkg::OP_TICK, 32'h1234_5678, 8'h00, 8'h00, 6'd0, 7'd0},
		'{fcsa_pkg::OP_TICK, 32'h0, 8'h00, 8'h00, 6'd0, 7'd0},
		'{fcsa_pkg::OP_READ, 32'h0, 8'h00, 8'h00, 6'd2, 7'd0},
		'{fcsa_pkg::OP_READ, 32'h0, 8'h00, 8'h00, 6'd63, 7'd0},
		'{fcsa_pkg::OP_QUERY, 32'h0, 8'h00, 8'h01, 6'd0, 7'd0},
		'{fcsa_pkg::OP_QUERY, 32'h0, 8'h00, 8'hFF, 6'd0, 7'd127},
		'{fcsa_pkg::OP_QUERY, 32'h0, 8'h00, 8'h08, 6'd0, 7'd1},
		'{fcsa_pkg::OP_QUERY, 32'h0, 8'h00, 8'h00, 6'd0, 7'd64},
		'{fcsa_pkg::OP_CLEAR, 32'h0, 8'h00, 8'h00, 6'd0, 7'd0},
		'{fcsa_pkg::OP_READ, 32'h0, 8'h00, 8'h00, 6'd0, 7'd0}
	};

	initial begin
		fcsa_pkg::cmd_t c;
		fcsa_pkg::result_t r;
		wipe_table();
		ticks = '0;
		threshold = fcsa_pkg::THRESHOLD_RESET;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows; the first few have results obvious right after reset
		foreach (directed_rows[k]) begin
			c = make_cmd(directed_rows[k].op, directed_rows[k].code, directed_rows[k].status,
				directed_rows[k].mask, directed_rows[k].idx, directed_rows[k].cap);
			if (k < 5) begin
				r = '0;
				r.last_flag = 1'b1;
				send_command(c);
				if (pending_results[$] != r)
					report_mismatch($sformatf("predictor disagrees on directed row %0d", k));
			end else begin
				send_command(c);
			end
		end
		// fill the table past full to exercise the circular overwrite
		for (int k = 0; k < 70; k++)
			send_command(make_cmd(fcsa_pkg::OP_ADD, 32'h100 + k, 8'($urandom), 8'h0, 6'h0,
				7'h0));
		send_command(make_cmd(fcsa_pkg::OP_QUERY, 32'h0, 8'h0, 8'hFF, 6'h0, 7'd64));
		drain_results();

		// random phases over several thresholds, extremes among them
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_threshold(16'd1);
				1: write_threshold(16'd3);
				2: write_threshold(16'hFFFF);
				3: write_threshold(16'd0);
				4: write_threshold(16'd12);
				default: write_threshold(fcsa_pkg::THRESHOLD_RESET);
			endcase
			case (ph % 4)
				0: sender_idle_pct = 0;
				1: sender_idle_pct = 48;
				2: sender_idle_pct = 19;
				default: sender_idle_pct = 0;
			endcase
			for (int k = 0; k < 60; k++)
				send_command(random_cmd());
			drain_results();
		end

		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

[fault_code_store_with_aging.f]
rtl/core/fcsa_pkg.sv
rtl/core/fault_code_store_with_aging.sv
verif/fault_code_store_with_aging_tb.sv
